FILE: rtl/avdv_pkg.sv
`timescale 1ns / 1ps

package avdv_pkg;

    // Field and register widths
    localparam int ADC_W     = 16;
    localparam int SUM_W     = 24;
    localparam int CNT_W     = 8;
    localparam int MV_W      = 17;
    localparam int OHM_W     = 24;
    localparam int SRC_W     = 20;
    localparam int CHG_W     = 16;
    localparam int CFG_W     = 24;
    localparam int CFG_IDX_W = 3;

    // Shared divider sizing
    localparam int DIV_NUM_W = 41;
    localparam int DIV_DEN_W = 25;
    localparam int DIV_CNT_W = 6;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_MV       = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_MV       = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_UPPER_OHMS   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_LOWER_OHMS   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_COUNT = 3'd4;

    // Register reset values
    localparam logic [MV_W-1:0]  MIN_MV_RST       = 17'd3000;
    localparam logic [MV_W-1:0]  MAX_MV_RST       = 17'd4200;
    localparam logic [OHM_W-1:0] UPPER_OHMS_RST   = 24'd100000;
    localparam logic [OHM_W-1:0] LOWER_OHMS_RST   = 24'd100000;
    localparam logic [CNT_W-1:0] SAMPLE_COUNT_RST = 8'd1;

    localparam logic [SRC_W-1:0] SRC_LIMIT   = 20'hFFFFF;
    localparam logic [CHG_W-1:0] CHARGE_FULL = 16'hFFFF;

    // Divider request and status
    typedef struct packed {
        logic                 start;
        logic [DIV_CNT_W-1:0] bits;
    } div_req_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_sts_t;

endpackage

FILE: rtl/averaged_divider_voltmeter_top.sv
`timescale 1ns / 1ps

// Divider voltmeter: takes tap readings in millivolts, averages sample_count of them
// (or maps one at once when direct is set) and reports the source voltage, saturated
// to 20 bits, with a 16-bit charge that is 0 at or below min_mv and 0xFFFF at or above
// max_mv. A sample that only adds to the running sum leaves the input ready; one
// that triggers an update keeps the input not ready until its result is moved into the
// output register: one shared bit-serial divider runs up to four divisions in turn
// (average 24 steps, divider top 41, source voltage 41, charge 33); the result then
// sits in an output register while the next request is taken.
module averaged_divider_voltmeter_top (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  cfg_wr_en,
    input  logic [avdv_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [avdv_pkg::CFG_W-1:0]            cfg_wdata,
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  logic [avdv_pkg::ADC_W-1:0]            s_adc_mv,
    input  logic                                  s_direct,
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic [avdv_pkg::SRC_W-1:0]            m_source_mv,
    output logic [avdv_pkg::CHG_W-1:0]            m_charge
);

    localparam int ADC_W = avdv_pkg::ADC_W;
    localparam int SUM_W = avdv_pkg::SUM_W;
    localparam int CNT_W = avdv_pkg::CNT_W;
    localparam int MV_W  = avdv_pkg::MV_W;
    localparam int OHM_W = avdv_pkg::OHM_W;
    localparam int SRC_W = avdv_pkg::SRC_W;
    localparam int CHG_W = avdv_pkg::CHG_W;
    localparam int NUM_W = avdv_pkg::DIV_NUM_W;
    localparam int DEN_W = avdv_pkg::DIV_DEN_W;
    localparam int DCN_W = avdv_pkg::DIV_CNT_W;
    localparam int MUL_W = 24;

    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_AVG_DIV = 4'd1;
    localparam logic [3:0] S_TOP_MUL = 4'd2;
    localparam logic [3:0] S_TOP_DIV = 4'd3;
    localparam logic [3:0] S_MAP_MUL = 4'd4;
    localparam logic [3:0] S_MAP_DIV = 4'd5;
    localparam logic [3:0] S_CHG_CHK = 4'd6;
    localparam logic [3:0] S_CHG_DIV = 4'd7;
    localparam logic [3:0] S_OUT     = 4'd8;

    // Configuration registers
    logic [MV_W-1:0]  min_mv_reg;
    logic [MV_W-1:0]  max_mv_reg;
    logic [OHM_W-1:0] upper_ohms_reg;
    logic [OHM_W-1:0] lower_ohms_reg;
    logic [CNT_W-1:0] sample_count_reg;

    // Sequencer and datapath
    logic [3:0]       state_reg, state_next;
    logic             div_start_reg, div_start_next;
    logic [SUM_W-1:0] sum_reg, sum_next;
    logic [CNT_W-1:0] idx_reg, idx_next;
    logic [SUM_W-1:0] avg_reg, avg_next;
    logic [NUM_W-1:0] prod_reg, prod_next;
    logic [OHM_W:0]   rsum_reg, rsum_next;
    logic [MV_W-1:0]  divtop_reg, divtop_next;
    logic             span_neg_reg, span_neg_next;
    logic [SRC_W-1:0] volt_reg, volt_next;
    logic [CHG_W-1:0] charge_reg, charge_next;
    logic             m_valid_reg, m_valid_next;
    logic [SRC_W-1:0] m_source_mv_reg, m_source_mv_next;
    logic [CHG_W-1:0] m_charge_reg, m_charge_next;

    logic [CNT_W-1:0]   count_eff;
    logic [SUM_W-1:0]   sum_add;
    logic [CNT_W-1:0]   idx_add;
    logic [OHM_W:0]     rsum_now;
    logic [MV_W:0]      span_s;
    logic [MV_W-1:0]    span_mag;
    logic [MV_W-1:0]    chg_den;
    logic [SRC_W-1:0]   volt_off;
    logic [NUM_W:0]     pos_sum;
    logic [MUL_W-1:0]   mul_a, mul_b;
    logic [2*MUL_W-1:0] mul_p;

    avdv_pkg::div_req_t        div_req;
    avdv_pkg::div_sts_t        div_sts;
    logic [NUM_W-1:0]          div_numer;
    logic [DEN_W-1:0]          div_denom;
    logic [NUM_W-1:0]          div_quot;

    // Write configuration
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            min_mv_reg       <= avdv_pkg::MIN_MV_RST;
            max_mv_reg       <= avdv_pkg::MAX_MV_RST;
            upper_ohms_reg   <= avdv_pkg::UPPER_OHMS_RST;
            lower_ohms_reg   <= avdv_pkg::LOWER_OHMS_RST;
            sample_count_reg <= avdv_pkg::SAMPLE_COUNT_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                avdv_pkg::CFG_MIN_MV:       min_mv_reg       <= cfg_wdata[MV_W-1:0];
                avdv_pkg::CFG_MAX_MV:       max_mv_reg       <= cfg_wdata[MV_W-1:0];
                avdv_pkg::CFG_UPPER_OHMS:   upper_ohms_reg   <= cfg_wdata[OHM_W-1:0];
                avdv_pkg::CFG_LOWER_OHMS:   lower_ohms_reg   <= cfg_wdata[OHM_W-1:0];
                avdv_pkg::CFG_SAMPLE_COUNT: sample_count_reg <= cfg_wdata[CNT_W-1:0];
                default: ;
            endcase
        end
    end

    // Shared divider
    avdv_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .div_req (div_req),
        .numer   (div_numer),
        .denom   (div_denom),
        .div_sts (div_sts),
        .quot    (div_quot)
    );

    // Helper arithmetic
    always_comb begin
        count_eff = (sample_count_reg == '0) ? CNT_W'(1) : sample_count_reg;
        sum_add   = sum_reg + SUM_W'(s_adc_mv);
        idx_add   = idx_reg + CNT_W'(1);
        rsum_now  = {1'b0, upper_ohms_reg} + {1'b0, lower_ohms_reg};
        span_s    = {1'b0, max_mv_reg} - {1'b0, min_mv_reg};
        span_mag  = span_s[MV_W] ? MV_W'(-span_s) : span_s[MV_W-1:0];
        chg_den   = max_mv_reg - min_mv_reg;
        volt_off  = volt_reg - SRC_W'(min_mv_reg);
        pos_sum   = (NUM_W+1)'(min_mv_reg) + {1'b0, div_quot};
    end

    // Share one multiplier across the mapping steps
    always_comb begin
        unique case (state_reg)
            S_TOP_MUL: begin
                mul_a = MUL_W'(max_mv_reg);
                mul_b = lower_ohms_reg;
            end
            S_MAP_MUL: begin
                mul_a = MUL_W'(span_mag);
                mul_b = avg_reg;
            end
            S_CHG_CHK: begin
                mul_a = MUL_W'(volt_off[MV_W-1:0]);
                mul_b = MUL_W'(avdv_pkg::CHARGE_FULL);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
        mul_p = mul_a * mul_b;
    end

    // Select divider operands by step
    always_comb begin
        div_req.start = div_start_reg;
        unique case (state_reg)
            S_AVG_DIV: begin
                div_req.bits = DCN_W'(SUM_W);
                div_numer    = {avg_reg, {(NUM_W-SUM_W){1'b0}}};
                div_denom    = DEN_W'(count_eff);
            end
            S_TOP_DIV: begin
                div_req.bits = DCN_W'(NUM_W);
                div_numer    = prod_reg;
                div_denom    = rsum_reg;
            end
            S_MAP_DIV: begin
                div_req.bits = DCN_W'(NUM_W);
                div_numer    = prod_reg;
                div_denom    = DEN_W'(divtop_reg);
            end
            S_CHG_DIV: begin
                div_req.bits = DCN_W'(MV_W + CHG_W);
                div_numer    = {prod_reg[MV_W+CHG_W-1:0], {(NUM_W-MV_W-CHG_W){1'b0}}};
                div_denom    = DEN_W'(chg_den);
            end
            default: begin
                div_req.bits = DCN_W'(1);
                div_numer    = '0;
                div_denom    = DEN_W'(1);
            end
        endcase
    end

    assign s_ready = (state_reg == S_IDLE);

    // Sequence one update
    always_comb begin
        state_next       = state_reg;
        div_start_next   = 1'b0;
        sum_next         = sum_reg;
        idx_next         = idx_reg;
        avg_next         = avg_reg;
        prod_next        = prod_reg;
        rsum_next        = rsum_reg;
        divtop_next      = divtop_reg;
        span_neg_next    = span_neg_reg;
        volt_next        = volt_reg;
        charge_next      = charge_reg;
        m_valid_next     = m_valid_reg;
        m_source_mv_next = m_source_mv_reg;
        m_charge_next    = m_charge_reg;

        // Drop the result once taken
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    if (s_direct) begin
                        avg_next   = SUM_W'(s_adc_mv);
                        state_next = S_TOP_MUL;
                    end else if (idx_add < count_eff) begin
                        sum_next = sum_add;
                        idx_next = idx_add;
                    end else begin
                        avg_next       = sum_add;
                        sum_next       = '0;
                        idx_next       = '0;
                        div_start_next = 1'b1;
                        state_next     = S_AVG_DIV;
                    end
                end
            end
            S_AVG_DIV: begin
                if (div_sts.done) begin
                    avg_next   = div_quot[SUM_W-1:0];
                    state_next = S_TOP_MUL;
                end
            end
            S_TOP_MUL: begin
                prod_next = mul_p[NUM_W-1:0];
                rsum_next = rsum_now;
                if (rsum_now == '0) begin
                    volt_next  = SRC_W'(max_mv_reg);
                    state_next = S_CHG_CHK;
                end else begin
                    div_start_next = 1'b1;
                    state_next     = S_TOP_DIV;
                end
            end
            S_TOP_DIV: begin
                if (div_sts.done) begin
                    divtop_next = div_quot[MV_W-1:0];
                    if (div_quot[MV_W-1:0] == '0) begin
                        volt_next  = SRC_W'(max_mv_reg);
                        state_next = S_CHG_CHK;
                    end else begin
                        state_next = S_MAP_MUL;
                    end
                end
            end
            S_MAP_MUL: begin
                prod_next      = mul_p[NUM_W-1:0];
                span_neg_next  = span_s[MV_W];
                div_start_next = 1'b1;
                state_next     = S_MAP_DIV;
            end
            S_MAP_DIV: begin
                // Apply the offset and saturate
                if (div_sts.done) begin
                    if (span_neg_reg) begin
                        if (div_quot > NUM_W'(min_mv_reg)) begin
                            volt_next = '0;
                        end else begin
                            volt_next = SRC_W'(min_mv_reg - div_quot[MV_W-1:0]);
                        end
                    end else if (pos_sum > (NUM_W+1)'(avdv_pkg::SRC_LIMIT)) begin
                        volt_next = avdv_pkg::SRC_LIMIT;
                    end else begin
                        volt_next = pos_sum[SRC_W-1:0];
                    end
                    state_next = S_CHG_CHK;
                end
            end
            S_CHG_CHK: begin
                if (volt_reg <= SRC_W'(min_mv_reg)) begin
                    charge_next = '0;
                    state_next  = S_OUT;
                end else if (volt_reg >= SRC_W'(max_mv_reg)) begin
                    charge_next = avdv_pkg::CHARGE_FULL;
                    state_next  = S_OUT;
                end else begin
                    prod_next      = mul_p[NUM_W-1:0];
                    div_start_next = 1'b1;
                    state_next     = S_CHG_DIV;
                end
            end
            S_CHG_DIV: begin
                if (div_sts.done) begin
                    charge_next = div_quot[CHG_W-1:0];
                    state_next  = S_OUT;
                end
            end
            S_OUT: begin
                // Hold until the output register is free
                if (!m_valid_reg || m_ready) begin
                    m_valid_next     = 1'b1;
                    m_source_mv_next = volt_reg;
                    m_charge_next    = charge_reg;
                    state_next       = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            div_start_reg <= 1'b0;
            sum_reg       <= '0;
            idx_reg       <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            div_start_reg <= div_start_next;
            sum_reg       <= sum_next;
            idx_reg       <= idx_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    // Datapath
    always_ff @(posedge aclk) begin
        avg_reg         <= avg_next;
        prod_reg        <= prod_next;
        rsum_reg        <= rsum_next;
        divtop_reg      <= divtop_next;
        span_neg_reg    <= span_neg_next;
        volt_reg        <= volt_next;
        charge_reg      <= charge_next;
        m_source_mv_reg <= m_source_mv_next;
        m_charge_reg    <= m_charge_next;
    end

    assign m_valid     = m_valid_reg;
    assign m_source_mv = m_source_mv_reg;
    assign m_charge    = m_charge_reg;

    // The divider is never restarted while it runs
    a_start_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        div_start_reg |-> !div_sts.busy)
        else $error("divider restarted while busy");

    // A finished division lands only in a divide step
    a_done_state: assert property (@(posedge aclk) disable iff (!aresetn)
        div_sts.done |-> (state_reg == S_AVG_DIV || state_reg == S_TOP_DIV ||
                          state_reg == S_MAP_DIV || state_reg == S_CHG_DIV))
        else $error("division finished outside a divide step");

    // A direct request always starts a mapping
    a_direct_maps: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && s_direct) |=> (state_reg == S_TOP_MUL))
        else $error("direct request did not start a mapping");

    // Zero volts always reports empty
    a_zero_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_source_mv_reg == '0) |-> (m_charge_reg == '0))
        else $error("charge nonzero at zero volts");

endmodule

FILE: rtl/avdv_div.sv
`timescale 1ns / 1ps

module avdv_div (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  avdv_pkg::div_req_t                 div_req,
    input  logic [avdv_pkg::DIV_NUM_W-1:0]     numer,
    input  logic [avdv_pkg::DIV_DEN_W-1:0]     denom,
    output avdv_pkg::div_sts_t                 div_sts,
    output logic [avdv_pkg::DIV_NUM_W-1:0]     quot
);

    localparam int NUM_W = avdv_pkg::DIV_NUM_W;
    localparam int DEN_W = avdv_pkg::DIV_DEN_W;
    localparam int CNT_W = avdv_pkg::DIV_CNT_W;

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [NUM_W-1:0] q_reg, q_next;
    logic [DEN_W-1:0] rem_reg, rem_next;
    logic [DEN_W-1:0] den_reg, den_next;
    logic [DEN_W:0]   shifted;
    logic [DEN_W:0]   diff;

    // One restoring step per cycle: quotient bits shift in from the right
    always_comb begin
        shifted   = {rem_reg, q_reg[NUM_W-1]};
        diff      = shifted - {1'b0, den_reg};
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        q_next    = q_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        if (div_req.start) begin
            busy_next = 1'b1;
            cnt_next  = div_req.bits;
            q_next    = numer;
            rem_next  = '0;
            den_next  = denom;
        end else if (busy_reg) begin
            if (shifted >= {1'b0, den_reg}) begin
                rem_next = diff[DEN_W-1:0];
                q_next   = {q_reg[NUM_W-2:0], 1'b1};
            end else begin
                rem_next = shifted[DEN_W-1:0];
                q_next   = {q_reg[NUM_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Datapath
    always_ff @(posedge aclk) begin
        q_reg   <= q_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    assign div_sts.busy = busy_reg;
    assign div_sts.done = done_reg;
    assign quot         = q_reg;

endmodule
